// ----- hdl/gslm_pkg.sv -----
// Package with the types, codes and fixed constants of the gapped sector layout mapper.
package gslm_pkg;

  typedef enum logic [1:0] {
    MODE_PLAIN   = 2'd0,
    MODE_SLOTTED = 2'd1,
    MODE_GROUPED = 2'd2,
    MODE_AUTO    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    OP_NEXT_RUN  = 2'd0,
    OP_PHYS_SIZE = 2'd1,
    OP_SECTORS   = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  localparam int unsigned APB_ADDR_W = 3;
  localparam logic REG_BLOCK_SIZE = 1'b0;
  localparam logic REG_REQ_MODE   = 1'b1;

  localparam logic [15:0] BLOCK_SIZE_RST  = 16'd512;
  localparam logic [15:0] AUTO_SLOTTED_BS = 16'd520;
  localparam logic [15:0] AUTO_GROUPED_BS = 16'd522;

  localparam int unsigned DIV_BITS  = 48;
  localparam int unsigned CELL_BITS = 4;
  localparam int unsigned NUM_CELLS = DIV_BITS / CELL_BITS;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] logical_sector;
    logic [31:0] sector_count;
    logic [47:0] physical_bytes;
  } req_t;

  typedef struct packed {
    logic [1:0]  resolved_mode;
    logic [31:0] run_sectors;
    logic [44:0] unit_offset;
    logic [15:0] unit_size;
    logic [23:0] byte_offset_in_unit;
    logic [7:0]  unit_capacity;
    logic [7:0]  sector_index_in_unit;
    logic [47:0] physical_size;
    logic [31:0] sector_total;
  } rsp_t;

  typedef struct packed {
    op_e         opcode;
    mode_e       mode;
    logic [31:0] lsec;
    logic [31:0] cnt;
  } ctx_t;

  typedef struct packed {
    logic [DIV_BITS-1:0] work;
    logic [15:0]         rem;
    logic [15:0]         divisor;
  } div_t;

  typedef struct packed {
    ctx_t ctx;
    div_t div;
  } cell_t;

endpackage

// ----- hdl/gslm_stream_if.sv -----
// Valid/ready stream interface that carries one payload beat.
interface gslm_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/gapped_sector_layout_mapper.sv -----
// Top level of the gapped sector layout mapper: configuration registers and the cell chain.
//
//   channel  dir  protocol   beat
//   req_i    in   valid/rdy  opcode, logical_sector, sector_count, physical_bytes
//   rsp_o    out  valid/rdy  resolved_mode, run fields, physical_size, sector_total
//   apb      in   APB write  block_size at 0x0, requested_mode at 0x4
//
// One beat enters per cycle unless a stalled successor holds the chain; each result passes a front
// stage, twelve divider cells of four quotient bits each, and the output register.
// Reset clears every stage valid and sets block_size to 512 and requested_mode to auto.
// Each stage holds while its successor is full and stalled; empty stages close up, so
// requests keep entering while a result waits at the output. Opcode 3 is taken and dropped.
module gapped_sector_layout_mapper #(
  parameter int unsigned SLOT_BYTES    = 1024,
  parameter int unsigned GROUP_SECTORS = 15,
  parameter int unsigned GROUP_BYTES   = 8192
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  gslm_stream_if.sink                     req_i,
  gslm_stream_if.source                   rsp_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gslm_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);
  import gslm_pkg::*;

  logic [15:0] block_size_q;
  logic [15:0] block_size_d;
  mode_e       req_mode_q;
  mode_e       req_mode_d;
  logic        cfg_write;
  logic        reg_sel;

  logic [NUM_CELLS:0] chain_valid;
  logic [NUM_CELLS:0] chain_ready;
  cell_t              chain_data [NUM_CELLS+1];

  assign pready    = 1'b1;
  assign reg_sel   = paddr[APB_ADDR_W-1];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    block_size_d = block_size_q;
    req_mode_d   = req_mode_q;
    if (cfg_write) begin
      case (reg_sel)
        REG_BLOCK_SIZE: block_size_d = pwdata[15:0];
        REG_REQ_MODE:   req_mode_d   = mode_e'(pwdata[1:0]);
        default:        block_size_d = block_size_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_size_q <= BLOCK_SIZE_RST;
      req_mode_q   <= MODE_AUTO;
    end else begin
      block_size_q <= block_size_d;
      req_mode_q   <= req_mode_d;
    end
  end

  assign prdata = (reg_sel == REG_REQ_MODE) ? {30'd0, req_mode_q} : {16'd0, block_size_q};

  gslm_front #(
    .SLOT_BYTES    (SLOT_BYTES),
    .GROUP_SECTORS (GROUP_SECTORS),
    .GROUP_BYTES   (GROUP_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .block_size_i (block_size_q),
    .req_mode_i   (req_mode_q),
    .valid_o      (chain_valid[0]),
    .ready_i      (chain_ready[0]),
    .cell_o       (chain_data[0])
  );

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    gslm_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .ready_o (chain_ready[g]),
      .cell_i  (chain_data[g]),
      .valid_o (chain_valid[g+1]),
      .ready_i (chain_ready[g+1]),
      .cell_o  (chain_data[g+1])
    );
  end

  gslm_back #(
    .SLOT_BYTES    (SLOT_BYTES),
    .GROUP_SECTORS (GROUP_SECTORS),
    .GROUP_BYTES   (GROUP_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (chain_valid[NUM_CELLS]),
    .ready_o      (chain_ready[NUM_CELLS]),
    .cell_i       (chain_data[NUM_CELLS]),
    .block_size_i (block_size_q),
    .rsp_o        (rsp_o)
  );
endmodule

// ----- hdl/gslm_front.sv -----
// Front stage: resolves the layout mode and loads the operands of the divider chain.
module gslm_front #(
  parameter int unsigned SLOT_BYTES    = 1024,
  parameter int unsigned GROUP_SECTORS = 15,
  parameter int unsigned GROUP_BYTES   = 8192
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  gslm_stream_if.sink         req_i,
  input  logic [15:0]         block_size_i,
  input  gslm_pkg::mode_e     req_mode_i,
  output logic                valid_o,
  input  logic                ready_i,
  output gslm_pkg::cell_t     cell_o
);
  import gslm_pkg::*;

  localparam logic [15:0]         SlotW    = 16'(SLOT_BYTES);
  localparam logic [15:0]         GroupSW  = 16'(GROUP_SECTORS);
  localparam logic [15:0]         GroupBW  = 16'(GROUP_BYTES);
  localparam logic [DIV_BITS-1:0] GroupRnd = DIV_BITS'(GROUP_SECTORS - 1);

  logic  valid_q;
  logic  valid_d;
  cell_t cell_q;
  cell_t cell_d;
  mode_e mode;
  op_e   op;
  logic  accept;

  assign op      = op_e'(req_i.payload.opcode);
  assign req_i.ready = !valid_q || ready_i;
  assign accept  = req_i.valid && req_i.ready;

  always_comb begin
    if (req_mode_i != MODE_AUTO) begin
      mode = req_mode_i;
    end else if (block_size_i == AUTO_SLOTTED_BS) begin
      mode = MODE_SLOTTED;
    end else if (block_size_i == AUTO_GROUPED_BS) begin
      mode = MODE_GROUPED;
    end else begin
      mode = MODE_PLAIN;
    end
  end

  always_comb begin
    cell_d.ctx.opcode  = op;
    cell_d.ctx.mode    = mode;
    cell_d.ctx.lsec    = req_i.payload.logical_sector;
    cell_d.ctx.cnt     = req_i.payload.sector_count;
    cell_d.div.rem     = '0;
    cell_d.div.divisor = GroupSW;
    cell_d.div.work    = DIV_BITS'(req_i.payload.logical_sector);
    case (op)
      OP_PHYS_SIZE: begin
        cell_d.div.work = DIV_BITS'(req_i.payload.sector_count) + GroupRnd;
      end
      OP_SECTORS: begin
        cell_d.div.work = req_i.payload.physical_bytes;
        case (mode)
          MODE_SLOTTED: cell_d.div.divisor = SlotW;
          MODE_GROUPED: cell_d.div.divisor = GroupBW;
          default:      cell_d.div.divisor = block_size_i;
        endcase
      end
      default: begin
        cell_d.div.work = DIV_BITS'(req_i.payload.logical_sector);
      end
    endcase
  end

  always_comb begin
    valid_d = valid_q;
    if (req_i.ready) begin
      valid_d = accept && (op != OP_NONE);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;
endmodule

// ----- hdl/gslm_div_cell.sv -----
// Divider cell: retires four quotient bits of a restoring division per beat.
module gslm_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  gslm_pkg::cell_t cell_i,
  output logic            valid_o,
  input  logic            ready_i,
  output gslm_pkg::cell_t cell_o
);
  import gslm_pkg::*;

  logic                valid_q;
  cell_t               cell_q;
  cell_t               cell_d;
  logic [DIV_BITS-1:0] work;
  logic [15:0]         rem;
  logic [16:0]         trial;
  logic                q_bit;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    work  = cell_i.div.work;
    rem   = cell_i.div.rem;
    trial = '0;
    q_bit = 1'b0;
    for (int k = 0; k < CELL_BITS; k++) begin
      trial = {rem, work[DIV_BITS-1]};
      q_bit = trial >= {1'b0, cell_i.div.divisor};
      if (q_bit) begin
        rem = 16'(trial - {1'b0, cell_i.div.divisor});
      end else begin
        rem = trial[15:0];
      end
      work = {work[DIV_BITS-2:0], q_bit};
    end
    cell_d          = cell_i;
    cell_d.div.work = work;
    cell_d.div.rem  = rem;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      cell_q <= cell_d;
    end
  end

  assign valid_o = valid_q;
  assign cell_o  = cell_q;
endmodule

// ----- hdl/gslm_back.sv -----
// Back stage: one multiply shared by the opcodes, a second for the byte offset in the unit, and the result beat.
module gslm_back #(
  parameter int unsigned SLOT_BYTES    = 1024,
  parameter int unsigned GROUP_SECTORS = 15,
  parameter int unsigned GROUP_BYTES   = 8192
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  gslm_pkg::cell_t cell_i,
  input  logic [15:0]     block_size_i,
  gslm_stream_if.source   rsp_o
);
  import gslm_pkg::*;

  localparam logic [15:0] SlotW   = 16'(SLOT_BYTES);
  localparam logic [7:0]  GroupSW = 8'(GROUP_SECTORS);
  localparam logic [15:0] GroupBW = 16'(GROUP_BYTES);

  logic        valid_q;
  rsp_t        rsp_q;
  rsp_t        rsp_d;
  logic [31:0] quot;
  logic [7:0]  sin;
  logic [7:0]  left;
  logic [31:0] run;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] prod;

  assign quot  = cell_i.div.work[31:0];
  assign sin   = cell_i.div.rem[7:0];
  assign left  = GroupSW - sin;
  assign ready_o = !valid_q || rsp_o.ready;

  always_comb begin
    if (cell_i.ctx.cnt < {24'd0, left}) begin
      run = cell_i.ctx.cnt;
    end else begin
      run = {24'd0, left};
    end
    if (run == '0) begin
      run = 32'd1;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cell_i.ctx.opcode)
      OP_NEXT_RUN: begin
        if (cell_i.ctx.mode == MODE_SLOTTED) begin
          mul_a = cell_i.ctx.lsec;
          mul_b = SlotW;
        end else begin
          mul_a = quot;
          mul_b = GroupBW;
        end
      end
      OP_PHYS_SIZE: begin
        case (cell_i.ctx.mode)
          MODE_SLOTTED: begin
            mul_a = cell_i.ctx.cnt;
            mul_b = SlotW;
          end
          MODE_GROUPED: begin
            mul_a = quot;
            mul_b = GroupBW;
          end
          default: begin
            mul_a = cell_i.ctx.cnt;
            mul_b = block_size_i;
          end
        endcase
      end
      OP_SECTORS: begin
        case (cell_i.ctx.mode)
          MODE_SLOTTED: begin
            mul_a = quot;
            mul_b = 16'd1;
          end
          MODE_GROUPED: begin
            mul_a = quot;
            mul_b = {8'd0, GroupSW};
          end
          default: begin
            mul_a = (block_size_i == '0) ? '0 : quot;
            mul_b = 16'd1;
          end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = {16'd0, mul_a} * {32'd0, mul_b};

  always_comb begin
    rsp_d               = '0;
    rsp_d.resolved_mode = cell_i.ctx.mode;
    case (cell_i.ctx.opcode)
      OP_NEXT_RUN: begin
        rsp_d.unit_offset = prod[44:0];
        if (cell_i.ctx.mode == MODE_SLOTTED) begin
          rsp_d.run_sectors   = 32'd1;
          rsp_d.unit_size     = SlotW;
          rsp_d.unit_capacity = 8'd1;
        end else begin
          rsp_d.run_sectors          = run;
          rsp_d.unit_size            = GroupBW;
          rsp_d.byte_offset_in_unit  = {16'd0, sin} * {8'd0, block_size_i};
          rsp_d.unit_capacity        = GroupSW;
          rsp_d.sector_index_in_unit = sin;
        end
      end
      OP_PHYS_SIZE: begin
        rsp_d.physical_size = prod;
      end
      OP_SECTORS: begin
        rsp_d.sector_total = prod[31:0];
      end
      default: begin
        rsp_d.physical_size = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_o.valid   = valid_q;
  assign rsp_o.payload = rsp_q;

  a_mode_resolved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> rsp_q.resolved_mode != MODE_AUTO)
    else $error("result beat carries an unresolved layout mode");

  a_run_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && rsp_q.unit_capacity != '0 |->
      rsp_q.run_sectors != '0 && rsp_q.run_sectors <= {24'd0, rsp_q.unit_capacity})
    else $error("run length outside its unit");

  a_index_in_unit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && rsp_q.unit_capacity != '0 |->
      rsp_q.sector_index_in_unit < rsp_q.unit_capacity)
    else $error("sector index beyond unit capacity");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> !(rsp_q.physical_size != '0 && rsp_q.sector_total != '0) &&
      !(rsp_q.unit_capacity != '0 &&
        (rsp_q.physical_size != '0 || rsp_q.sector_total != '0)))
    else $error("result beat mixes fields of different opcodes");
endmodule

// ----- tb/gapped_sector_layout_mapper_checker.sv -----
// Checker that watches the mapper's channels, predicts each result and compares it.
`timescale 1ns / 100ps

module gapped_sector_layout_mapper_checker #(
  parameter int unsigned SLOT_BYTES    = 1024,
  parameter int unsigned GROUP_SECTORS = 15,
  parameter int unsigned GROUP_BYTES   = 8192
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            req_valid_i,
  input  logic                            req_ready_i,
  input  gslm_pkg::req_t                  req_payload_i,
  input  logic                            rsp_valid_i,
  input  logic                            rsp_ready_i,
  input  gslm_pkg::rsp_t                  rsp_payload_i,
  input  logic                            psel_i,
  input  logic                            penable_i,
  input  logic                            pwrite_i,
  input  logic                            pready_i,
  input  logic [gslm_pkg::APB_ADDR_W-1:0] paddr_i,
  input  logic [31:0]                     pwdata_i,
  output int                              fail_count_o,
  output int                              pending_o,
  output int                              results_o
);
  import gslm_pkg::*;

  logic [15:0] block_size_q;
  logic [1:0]  req_mode_q;
  rsp_t        expected_layouts[$];
  int          mismatches;
  int          results_seen;

  function automatic rsp_t map_request(req_t rq, logic [15:0] bs, logic [1:0] req_mode);
    mode_e       eff;
    logic [63:0] lsec;
    logic [63:0] cnt;
    logic [63:0] pbytes;
    logic [63:0] sin;
    logic [63:0] left;
    logic [63:0] run;
    logic [63:0] wide;
    rsp_t        r;
    lsec   = {32'd0, rq.logical_sector};
    cnt    = {32'd0, rq.sector_count};
    pbytes = {16'd0, rq.physical_bytes};
    if (req_mode != MODE_AUTO) begin
      eff = mode_e'(req_mode);
    end else if (bs == AUTO_SLOTTED_BS) begin
      eff = MODE_SLOTTED;
    end else if (bs == AUTO_GROUPED_BS) begin
      eff = MODE_GROUPED;
    end else begin
      eff = MODE_PLAIN;
    end
    r = '0;
    r.resolved_mode = eff;
    case (rq.opcode)
      OP_NEXT_RUN: begin
        if (eff == MODE_SLOTTED) begin
          wide = lsec * SLOT_BYTES;
          r.run_sectors   = 32'd1;
          r.unit_offset   = wide[44:0];
          r.unit_size     = SLOT_BYTES[15:0];
          r.unit_capacity = 8'd1;
        end else begin
          sin  = lsec % GROUP_SECTORS;
          left = GROUP_SECTORS - sin;
          run  = (cnt < left) ? cnt : left;
          if (run == 0) run = 64'd1;
          wide = (lsec / GROUP_SECTORS) * GROUP_BYTES;
          r.run_sectors = run[31:0];
          r.unit_offset = wide[44:0];
          r.unit_size   = GROUP_BYTES[15:0];
          wide = sin * bs;
          r.byte_offset_in_unit  = wide[23:0];
          r.unit_capacity        = GROUP_SECTORS[7:0];
          r.sector_index_in_unit = sin[7:0];
        end
      end
      OP_PHYS_SIZE: begin
        if (eff == MODE_SLOTTED) wide = cnt * SLOT_BYTES;
        else if (eff == MODE_GROUPED)
          wide = ((cnt + GROUP_SECTORS - 1) / GROUP_SECTORS) * GROUP_BYTES;
        else wide = cnt * bs;
        r.physical_size = wide[47:0];
      end
      OP_SECTORS: begin
        if (eff == MODE_SLOTTED) wide = pbytes / SLOT_BYTES;
        else if (eff == MODE_GROUPED) wide = (pbytes / GROUP_BYTES) * GROUP_SECTORS;
        else if (bs != 0) wide = pbytes / bs;
        else wide = '0;
        r.sector_total = wide[31:0];
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      block_size_q = BLOCK_SIZE_RST;
      req_mode_q   = MODE_AUTO;
      expected_layouts.delete();
      mismatches   = 0;
      results_seen = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        results_seen++;
        if (expected_layouts.size() == 0) begin
          $error("Result beat arrived with no request outstanding.");
          mismatches++;
        end else begin
          want = expected_layouts.pop_front();
          check_field("resolved_mode", want.resolved_mode, rsp_payload_i.resolved_mode);
          check_field("run_sectors", want.run_sectors, rsp_payload_i.run_sectors);
          check_field("unit_offset", want.unit_offset, rsp_payload_i.unit_offset);
          check_field("unit_size", want.unit_size, rsp_payload_i.unit_size);
          check_field("byte_offset_in_unit", want.byte_offset_in_unit,
                      rsp_payload_i.byte_offset_in_unit);
          check_field("unit_capacity", want.unit_capacity, rsp_payload_i.unit_capacity);
          check_field("sector_index_in_unit", want.sector_index_in_unit,
                      rsp_payload_i.sector_index_in_unit);
          check_field("physical_size", want.physical_size, rsp_payload_i.physical_size);
          check_field("sector_total", want.sector_total, rsp_payload_i.sector_total);
        end
      end
      if (req_valid_i && req_ready_i && req_payload_i.opcode != OP_NONE)
        expected_layouts.push_back(map_request(req_payload_i, block_size_q, req_mode_q));
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[APB_ADDR_W-1:2])
          REG_BLOCK_SIZE: block_size_q = pwdata_i[15:0];
          REG_REQ_MODE:   req_mode_q   = pwdata_i[1:0];
          default: ;
        endcase
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= expected_layouts.size();
    results_o    <= results_seen;
  end

endmodule

// ----- tb/gapped_sector_layout_mapper_tb.sv -----
// Testbench top for the gapped sector layout mapper: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module gapped_sector_layout_mapper_tb;
  import gslm_pkg::*;

  localparam int unsigned SLOT_BYTES    = 1024;
  localparam int unsigned GROUP_SECTORS = 15;
  localparam int unsigned GROUP_BYTES   = 8192;
  localparam int          DRAIN_CYCLES  = 24;
  localparam int          RANDOM_PHASES = 12;
  localparam int          PHASE_ITEMS   = 110;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;
  int                    results;
  int                    requests_sent;
  int                    settings_used;
  int                    sink_stall;
  bit                    sender_steady;
  bit                    sink_steady;

  gslm_stream_if #(.payload_t(req_t)) req_if ();
  gslm_stream_if #(.payload_t(rsp_t)) rsp_if ();

  gapped_sector_layout_mapper #(
    .SLOT_BYTES   (SLOT_BYTES),
    .GROUP_SECTORS(GROUP_SECTORS),
    .GROUP_BYTES  (GROUP_BYTES)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  gapped_sector_layout_mapper_checker #(
    .SLOT_BYTES   (SLOT_BYTES),
    .GROUP_SECTORS(GROUP_SECTORS),
    .GROUP_BYTES  (GROUP_BYTES)
  ) layout_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_if.valid),
    .req_ready_i  (req_if.ready),
    .req_payload_i(req_if.payload),
    .rsp_valid_i  (rsp_if.valid),
    .rsp_ready_i  (rsp_if.ready),
    .rsp_payload_i(rsp_if.payload),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .results_o    (results)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("FAIL gapped_sector_layout_mapper");
    $finish;
  end

  function automatic int pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin
    rsp_if.ready = 1'b0;
    sink_stall   = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (sink_stall > 0) begin
        rsp_if.ready = 1'b0;
        sink_stall--;
      end else begin
        rsp_if.ready = 1'b1;
        if (!sink_steady && $urandom_range(0, 3) == 0) sink_stall = pick_gap();
      end
    end
  end

  function automatic req_t make_req(op_e op, logic [31:0] lsec, logic [31:0] cnt,
                                    logic [47:0] pbytes);
    req_t rq;
    rq.opcode         = op;
    rq.logical_sector = lsec;
    rq.sector_count   = cnt;
    rq.physical_bytes = pbytes;
    return rq;
  endfunction

  function automatic req_t random_request();
    req_t        rq;
    int unsigned roll;
    logic [63:0] wide;
    roll = $urandom_range(0, 19);
    if (roll < 8) rq.opcode = OP_NEXT_RUN;
    else if (roll < 13) rq.opcode = OP_PHYS_SIZE;
    else if (roll < 18) rq.opcode = OP_SECTORS;
    else rq.opcode = OP_NONE;
    case ($urandom_range(0, 3))
      0: rq.logical_sector = $urandom;
      1: rq.logical_sector = $urandom_range(0, 60);
      2: rq.logical_sector = GROUP_SECTORS * $urandom_range(0, 100000) + $urandom_range(0, 1)
                             * (GROUP_SECTORS - 1);
      default: rq.logical_sector = 32'hFFFF_FFFF - $urandom_range(0, 20);
    endcase
    case ($urandom_range(0, 4))
      0: rq.sector_count = $urandom;
      1: rq.sector_count = $urandom_range(1, 20);
      2: rq.sector_count = '0;
      3: rq.sector_count = $urandom_range(0, 5000);
      default: rq.sector_count = 32'hFFFF_FFFF - $urandom_range(0, 20);
    endcase
    wide = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: rq.physical_bytes = wide[47:0];
      1: rq.physical_bytes = 48'($urandom_range(0, 100000));
      2: rq.physical_bytes = 48'hFFFF_FFFF_FFFF - $urandom_range(0, 3);
      default: rq.physical_bytes = 48'(SLOT_BYTES * $urandom_range(0, 1 << 20)
                                       - $urandom_range(0, 1));
    endcase
    return rq;
  endfunction

  task automatic send(input req_t rq);
    int gap;
    gap = sender_steady ? 0 : pick_gap();
    if (gap > 0) begin
      req_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid   = 1'b1;
    req_if.payload = rq;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    @(negedge clk_i);
    req_if.valid = 1'b0;
    requests_sent++;
  endtask

  task automatic apb_write(input logic idx, input logic [31:0] data);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(input logic [15:0] bs, input mode_e mode);
    logic [31:0] upper;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    upper = $urandom;
    apb_write(REG_BLOCK_SIZE, {upper[31:16], bs});
    apb_write(REG_REQ_MODE, {upper[29:0], mode});
    settings_used++;
  endtask

  initial begin
    logic [15:0] bs;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    requests_sent  = 0;
    settings_used  = 1;
    sender_steady  = 1'b0;
    sink_steady    = 1'b0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: 512-byte sectors in auto mode resolve to plain.
    send(make_req(OP_NEXT_RUN, 32'd0, 32'd0, '0));
    send(make_req(OP_NEXT_RUN, 32'd14, 32'd100, '0));
    send(make_req(OP_NEXT_RUN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0));
    send(make_req(OP_PHYS_SIZE, '0, 32'hFFFF_FFFF, '0));
    send(make_req(OP_SECTORS, '0, '0, 48'hFFFF_FFFF_FFFF));
    send(make_req(OP_SECTORS, '0, '0, '0));
    send(make_req(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF));

    configure(16'd0, MODE_PLAIN);
    send(make_req(OP_SECTORS, '0, '0, 48'hFFFF_FFFF_FFFF));
    send(make_req(OP_PHYS_SIZE, '0, 32'hFFFF_FFFF, '0));
    send(make_req(OP_NEXT_RUN, 32'd7, 32'd3, '0));

    configure(16'd512, MODE_SLOTTED);
    send(make_req(OP_NEXT_RUN, 32'hFFFF_FFFF, 32'd0, '0));
    send(make_req(OP_PHYS_SIZE, '0, 32'hFFFF_FFFF, '0));
    send(make_req(OP_SECTORS, '0, '0, 48'hFFFF_FFFF_FFFF));

    configure(16'd65535, MODE_GROUPED);
    send(make_req(OP_NEXT_RUN, 32'd29, 32'd1, '0));
    send(make_req(OP_PHYS_SIZE, '0, 32'hFFFF_FFFF, '0));
    send(make_req(OP_SECTORS, '0, '0, 48'hFFFF_FFFF_FFFF));

    configure(AUTO_SLOTTED_BS, MODE_AUTO);
    send(make_req(OP_NEXT_RUN, 32'd5, 32'd9, '0));
    configure(AUTO_GROUPED_BS, MODE_AUTO);
    send(make_req(OP_NEXT_RUN, 32'd16, 32'd0, '0));

    configure(16'd65535, MODE_PLAIN);
    send(make_req(OP_NEXT_RUN, 32'd14, 32'd2, '0));
    send(make_req(OP_PHYS_SIZE, '0, 32'hFFFF_FFFF, '0));
    send(make_req(OP_SECTORS, '0, '0, 48'hFFFF_FFFF_FFFF));

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0: configure(AUTO_SLOTTED_BS, MODE_AUTO);
        1: configure(AUTO_GROUPED_BS, MODE_AUTO);
        2: configure(16'd0, MODE_PLAIN);
        3: configure(16'd65535, MODE_GROUPED);
        4: configure(16'd1, MODE_SLOTTED);
        5: configure(16'd65535, MODE_PLAIN);
        6: configure(16'd1, MODE_AUTO);
        default: begin
          case ($urandom_range(0, 3))
            0: bs = 16'(AUTO_SLOTTED_BS + $urandom_range(0, 1) * 2);
            1: bs = 16'($urandom_range(1, 4096));
            default: bs = 16'($urandom);
          endcase
          configure(bs, mode_e'($urandom_range(0, 3)));
        end
      endcase
      sender_steady = ($urandom_range(0, 3) == 0);
      sink_steady   = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n == PHASE_ITEMS / 2) begin
          wait (pending == 0);
          @(negedge clk_i);
        end
        send(random_request());
      end
    end

    wait (pending == 0);
    repeat (DRAIN_CYCLES * 2) @(negedge clk_i);
    $display("Sent %0d requests (directed extremes, then random) over %0d layout settings;",
             requests_sent, settings_used);
    $display("checked %0d result beats with %0d mismatches.", results, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS gapped_sector_layout_mapper");
    end else begin
      $display("FAIL gapped_sector_layout_mapper");
    end
    $finish;
  end

endmodule
